// ===== rtl/port_right_name_table_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef PORT_RIGHT_NAME_TABLE_MACROS_SVH
`define PORT_RIGHT_NAME_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PNT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PNT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pnt_pkg.sv =====
`default_nettype none
package pnt_pkg;

  typedef enum logic [2:0] {
    KIND_ALLOC_RECV = 3'd0,
    KIND_ALLOC_SO   = 3'd1,
    KIND_INSERT     = 3'd2,
    KIND_MODIFY     = 3'd3,
    KIND_DEALLOC    = 3'd4,
    KIND_QUERY      = 3'd5
  } pnt_kind_t;

  typedef enum logic [2:0] {
    RIGHT_SEND    = 3'd0,
    RIGHT_DEAD    = 3'd1,
    RIGHT_RECV    = 3'd2,
    RIGHT_SO      = 3'd3,
    RIGHT_PORTSET = 3'd4
  } pnt_right_t;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_BAD_NAME  = 3'd1;
  localparam logic [2:0] STAT_BAD_RIGHT = 3'd2;
  localparam logic [2:0] STAT_BAD_VALUE = 3'd3;
  localparam logic [2:0] STAT_OVERFLOW  = 3'd4;
  localparam logic [2:0] STAT_NO_SPACE  = 3'd5;

  localparam logic [31:0] MAX_REFS_RESET = 32'd65535;

  typedef struct packed {
    logic [2:0]         kind;
    logic [9:0]         name_index;
    logic [7:0]         name_generation;
    logic [2:0]         right;
    logic signed [31:0] delta;
    logic [7:0]         object_kind;
    logic [63:0]        object_id;
  } pnt_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  out_index;
    logic [7:0]  out_generation;
    logic [3:0]  type_bits;
    logic [7:0]  result_object_kind;
    logic [63:0] result_object_id;
  } pnt_out_t;

  // Per-entry control word; cleared after reset.
  typedef struct packed {
    logic       live;
    logic [7:0] gen;
    logic       recv;
    logic       so;
    logic       dead;
  } pnt_ctl_t;

  // Per-entry payload; written at allocation and when the send-right count changes.
  typedef struct packed {
    logic [31:0] send_refs;
    logic [63:0] uid;
    logic [9:0]  tslot;
    logic [63:0] tuid;
    logic [7:0]  okind;
    logic [63:0] oid;
  } pnt_dat_t;

  // Lowest clear bit: {found, position}.
  function automatic logic [5:0] first_zero(input logic [31:0] w);
    logic [5:0] r;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      if (!w[i]) begin
        r = {1'b1, 5'(i)};
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pnt_ram.sv =====
`default_nettype none
module pnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/port_right_name_table.sv =====
// Port-right name table: one item in flight at a time.
// An item taken from idle passes through S_RD and S_WB; the result strobe rises after S_WB
// and busy is low again in that same cycle, so a new item can be taken while the result
// is shown (steps: read entry, read second entry or free slot, write back).
// The receiver cannot stall: out_valid is a one-cycle strobe.
// Reset (rst_n low, synchronous) clears control state, then a clearing pass over
// min(SLOT_COUNT,1024) entries zeroes the entry table with busy held high.
`default_nettype none
module port_right_name_table import pnt_pkg::*; #(
  parameter int SLOT_COUNT = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output      logic        busy,
  input  wire pnt_in_t     in_item,
  output      logic        out_valid,
  output      pnt_out_t    out_item,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data
);

  localparam int USABLE = (SLOT_COUNT < 1024) ? SLOT_COUNT : 1024;
  localparam int IW     = (USABLE > 1) ? $clog2(USABLE) : 1;
  localparam int WORDS  = (USABLE + 31) / 32;
  localparam int WAW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int EW     = $bits(pnt_ctl_t) + $bits(pnt_dat_t);

  typedef enum logic [3:0] {
    S_CLR  = 4'b0001,
    S_IDLE = 4'b0010,
    S_RD   = 4'b0100,
    S_WB   = 4'b1000
  } pnt_state_t;

  pnt_state_t state_r, state_nxt;
  logic [IW-1:0]    clr_cnt_r, clr_cnt_nxt;
  pnt_in_t          item_r;
  logic [31:0]      max_refs_r;
  logic [63:0]      idc_r;
  logic [WORDS-1:0] summary_r;
  logic [WAW-1:0]   wsel_r;
  logic             full_r;
  pnt_ctl_t         ctl_s_r;
  pnt_dat_t         dat_s_r;
  logic             hit_r;
  logic [IW-1:0]    addr2_r;
  logic             out_valid_r;
  pnt_out_t         out_r;

  logic             accept;
  logic [31:0]      sum_pad;
  logic [5:0]       fz_word;
  logic [31:0]      word_pad;
  logic [5:0]       fz_bit;
  logic [IW-1:0]    slot_n;
  logic             hit;
  logic [IW-1:0]    addr2;

  // Memory ports
  logic             mem_re;
  logic [IW-1:0]    ent_raddr;
  logic [WAW-1:0]   bm_raddr;
  pnt_ctl_t         ctl_rdata;
  pnt_dat_t         dat_rdata;
  logic [EW-1:0]    ent_rdata;
  logic [31:0]      bm_rdata;
  logic             ctl_we, dat_we, bm_we;
  logic             ent_we;
  logic [IW-1:0]    ent_waddr;
  logic [WAW-1:0]   bm_waddr;
  pnt_ctl_t         ctl_wd;
  pnt_dat_t         dat_wd;
  logic [EW-1:0]    ent_wd;
  logic [31:0]      bm_wd;

  // Write-back stage
  logic [2:0]       wb_status;
  logic             wb_ctl_we, wb_dat_we, wb_bm_we, idc_inc;
  pnt_ctl_t         wb_ctl;
  pnt_dat_t         wb_dat;
  logic [31:0]      wb_bm;
  logic [WAW-1:0]   wb_word;
  logic [4:0]       wb_bit;
  logic [7:0]       new_gen;
  logic             do_adj, adj_free, do_free;
  logic [31:0]      delta_eff;
  logic [33:0]      adj_sum;
  logic             adj_neg, adj_over;
  pnt_out_t         wb_out;

  // Valid bits of a bitmap word: slots past the table end count as taken.
  function automatic logic [31:0] word_mask(input logic [WAW-1:0] w);
    logic [31:0] m;
    for (int b = 0; b < 32; b++) begin
      m[b] = ((32'(w) * 32 + 32'(b)) < USABLE);
    end
    return m;
  endfunction

  assign accept    = (state_r == S_IDLE) && start;
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Pick the lowest bitmap word that still has a free slot.
  always_comb begin
    sum_pad = '1;
    for (int i = 0; i < WORDS; i++) begin
      sum_pad[i] = summary_r[i];
    end
  end
  assign fz_word = first_zero(sum_pad);

  // First read results: lookup the named entry and the free slot.
  assign word_pad = bm_rdata | ~word_mask(wsel_r);
  assign fz_bit   = first_zero(word_pad);
  assign slot_n   = IW'(32'(wsel_r) * 32 + 32'(fz_bit[4:0]));
  assign hit      = (item_r.name_generation != 8'd0) &&
                    (32'(item_r.name_index) < USABLE) &&
                    ctl_rdata.live && (ctl_rdata.gen == item_r.name_generation);

  // Second read: the free slot for alloc, the target for a query, else the entry again.
  always_comb begin
    case (item_r.kind)
      KIND_ALLOC_RECV, KIND_ALLOC_SO: addr2 = slot_n;
      KIND_QUERY:                     addr2 = IW'(dat_rdata.tslot);
      default:                        addr2 = IW'(item_r.name_index);
    endcase
  end

  assign mem_re    = accept || (state_r == S_RD);
  assign ent_raddr = (state_r == S_IDLE) ? IW'(in_item.name_index) : addr2;
  assign bm_raddr  = (state_r == S_IDLE) ? WAW'(fz_word[4:0]) : WAW'(32'(addr2) >> 5);

  // Apply the update in the write-back cycle.
  assign wb_word   = WAW'(32'(addr2_r) >> 5);
  assign wb_bit    = 5'(32'(addr2_r));
  assign new_gen   = (ctl_rdata.gen == 8'hFF) ? 8'd1 : ctl_rdata.gen + 8'd1;
  assign delta_eff = (item_r.kind == KIND_DEALLOC) ? '1 : item_r.delta;
  assign adj_sum   = {2'b00, dat_s_r.send_refs} + {{2{delta_eff[31]}}, delta_eff};
  assign adj_neg   = adj_sum[33];
  assign adj_over  = !adj_neg && (adj_sum[32:0] > {1'b0, max_refs_r});

  always_comb begin
    wb_status = STAT_OK;
    wb_ctl_we = 1'b0;
    wb_dat_we = 1'b0;
    wb_bm_we  = 1'b0;
    idc_inc   = 1'b0;
    wb_ctl    = ctl_s_r;
    wb_dat    = dat_s_r;
    wb_bm     = bm_rdata;
    do_adj    = 1'b0;
    adj_free  = 1'b0;
    do_free   = 1'b0;
    wb_out    = '0;
    case (item_r.kind)
      KIND_ALLOC_RECV: begin
        if (full_r) begin
          wb_status = STAT_NO_SPACE;
        end else begin
          wb_ctl_we = 1'b1;
          wb_ctl    = '{live: 1'b1, gen: new_gen, recv: 1'b1, so: 1'b0, dead: 1'b0};
          wb_dat_we = 1'b1;
          wb_dat    = '{send_refs: '0, uid: idc_r, tslot: '0, tuid: '0,
                        okind: item_r.object_kind, oid: item_r.object_id};
          wb_bm_we  = 1'b1;
          wb_bm[wb_bit] = 1'b1;
          idc_inc   = 1'b1;
          wb_out.out_index      = 10'(addr2_r);
          wb_out.out_generation = new_gen;
        end
      end
      KIND_ALLOC_SO: begin
        if (!hit_r) begin
          wb_status = STAT_BAD_NAME;
        end else if (!ctl_s_r.recv) begin
          wb_status = STAT_BAD_RIGHT;
        end else if (full_r) begin
          wb_status = STAT_NO_SPACE;
        end else begin
          wb_ctl_we = 1'b1;
          wb_ctl    = '{live: 1'b1, gen: new_gen, recv: 1'b0, so: 1'b1, dead: 1'b0};
          wb_dat_we = 1'b1;
          wb_dat    = '{send_refs: '0, uid: idc_r, tslot: item_r.name_index,
                        tuid: dat_s_r.uid, okind: '0, oid: '0};
          wb_bm_we  = 1'b1;
          wb_bm[wb_bit] = 1'b1;
          idc_inc   = 1'b1;
          wb_out.out_index      = 10'(addr2_r);
          wb_out.out_generation = new_gen;
        end
      end
      KIND_INSERT: begin
        if (!hit_r) begin
          wb_status = STAT_BAD_NAME;
        end else if (!ctl_s_r.recv || ctl_s_r.dead) begin
          wb_status = STAT_BAD_RIGHT;
        end else if (dat_s_r.send_refs >= max_refs_r) begin
          wb_status = STAT_OVERFLOW;
        end else begin
          wb_dat_we = 1'b1;
          wb_dat.send_refs      = dat_s_r.send_refs + 32'd1;
          wb_out.out_index      = item_r.name_index;
          wb_out.out_generation = ctl_s_r.gen;
        end
      end
      KIND_MODIFY: begin
        if (!hit_r) begin
          wb_status = STAT_BAD_NAME;
        end else begin
          case (item_r.right)
            RIGHT_SEND: begin
              if (ctl_s_r.dead || (dat_s_r.send_refs == 32'd0)) begin
                wb_status = STAT_BAD_RIGHT;
              end else begin
                do_adj = 1'b1;
              end
            end
            RIGHT_DEAD: begin
              if (!ctl_s_r.dead) begin
                wb_status = STAT_BAD_RIGHT;
              end else begin
                do_adj   = 1'b1;
                adj_free = 1'b1;
              end
            end
            RIGHT_RECV: begin
              if (!ctl_s_r.recv) begin
                wb_status = STAT_BAD_RIGHT;
              end else if (item_r.delta == '0) begin
                wb_status = STAT_OK;
              end else if (item_r.delta != '1) begin
                wb_status = STAT_BAD_VALUE;
              end else if (dat_s_r.send_refs == 32'd0) begin
                do_free = 1'b1;
              end else begin
                // Send rights remain: turn into a dead name.
                wb_ctl_we   = 1'b1;
                wb_ctl.recv = 1'b0;
                wb_ctl.dead = 1'b1;
              end
            end
            RIGHT_SO: begin
              if (!ctl_s_r.so) begin
                wb_status = STAT_BAD_RIGHT;
              end else if (item_r.delta == '0) begin
                wb_status = STAT_OK;
              end else if (item_r.delta != '1) begin
                wb_status = STAT_BAD_VALUE;
              end else begin
                do_free = 1'b1;
              end
            end
            RIGHT_PORTSET: wb_status = STAT_BAD_RIGHT;
            default:       wb_status = STAT_BAD_VALUE;
          endcase
        end
      end
      KIND_DEALLOC: begin
        if (!hit_r) begin
          wb_status = STAT_BAD_NAME;
        end else if (ctl_s_r.dead) begin
          do_adj   = 1'b1;
          adj_free = 1'b1;
        end else if (ctl_s_r.so) begin
          do_free = 1'b1;
        end else if (dat_s_r.send_refs != 32'd0) begin
          do_adj = 1'b1;
        end else begin
          wb_status = STAT_BAD_RIGHT;
        end
      end
      KIND_QUERY: begin
        if (!hit_r) begin
          wb_status = STAT_BAD_NAME;
        end else begin
          if (ctl_s_r.dead) begin
            wb_out.type_bits = 4'b1000;
          end else begin
            wb_out.type_bits = {1'b0, ctl_s_r.so, (dat_s_r.send_refs != 32'd0),
                                ctl_s_r.recv};
          end
          if (!ctl_s_r.so) begin
            wb_out.result_object_kind = dat_s_r.okind;
            wb_out.result_object_id   = dat_s_r.oid;
          end else if ((32'(dat_s_r.tslot) < USABLE) && ctl_rdata.live &&
                       (dat_rdata.uid == dat_s_r.tuid)) begin
            // Resolve through the target only while it is the same object.
            wb_out.result_object_kind = dat_rdata.okind;
            wb_out.result_object_id   = dat_rdata.oid;
          end
        end
      end
      default: wb_status = STAT_BAD_VALUE;
    endcase

    if (do_adj) begin
      if (adj_neg) begin
        wb_status = STAT_BAD_VALUE;
      end else if (adj_over) begin
        wb_status = STAT_OVERFLOW;
      end else begin
        wb_dat_we        = 1'b1;
        wb_dat.send_refs = adj_sum[31:0];
        if (adj_free && (adj_sum[31:0] == 32'd0)) begin
          do_free = 1'b1;
        end
      end
    end

    if (do_free) begin
      wb_ctl_we = 1'b1;
      wb_ctl    = '{live: 1'b0, gen: ctl_s_r.gen, recv: 1'b0, so: 1'b0, dead: 1'b0};
      wb_bm_we  = 1'b1;
      wb_bm[wb_bit] = 1'b0;
    end
    wb_out.status = wb_status;
  end

  // Write ports: clearing pass or write-back.
  always_comb begin
    if (state_r == S_CLR) begin
      ctl_we    = 1'b1;
      dat_we    = 1'b0;
      bm_we     = (32'(clr_cnt_r) < WORDS);
      ent_waddr = clr_cnt_r;
      bm_waddr  = WAW'(clr_cnt_r);
      ctl_wd    = '0;
      dat_wd    = '0;
      bm_wd     = '0;
    end else begin
      ctl_we    = (state_r == S_WB) && wb_ctl_we;
      dat_we    = (state_r == S_WB) && wb_dat_we;
      bm_we     = (state_r == S_WB) && wb_bm_we;
      ent_waddr = addr2_r;
      bm_waddr  = wb_word;
      ctl_wd    = wb_ctl;
      dat_wd    = wb_dat;
      bm_wd     = wb_bm;
    end
  end

  // Control and payload share one entry word; an unchanged half is written back as read.
  assign ent_we = ctl_we || dat_we;
  assign ent_wd = {ctl_wd, dat_wd};
  assign {ctl_rdata, dat_rdata} = ent_rdata;

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      S_CLR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (32'(clr_cnt_r) == USABLE - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE:  if (start) state_nxt = S_RD;
      S_RD:    state_nxt = S_WB;
      S_WB:    state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      max_refs_r  <= MAX_REFS_RESET;
      idc_r       <= 64'd1;
      summary_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= (state_r == S_WB);
      if (cfg_wr_en) begin
        max_refs_r <= cfg_wr_data;
      end
      if ((state_r == S_WB) && idc_inc) begin
        idc_r <= idc_r + 64'd1;
      end
      // Track which bitmap words are full.
      if ((state_r == S_WB) && wb_bm_we) begin
        summary_r[wb_word] <= &(wb_bm | ~word_mask(wb_word));
      end
    end
  end

  // Payload registers: hold the item, the first read and the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
      wsel_r <= WAW'(fz_word[4:0]);
      full_r <= !fz_word[5];
    end
    if (state_r == S_RD) begin
      ctl_s_r <= ctl_rdata;
      dat_s_r <= dat_rdata;
      hit_r   <= hit;
      addr2_r <= addr2;
    end
    if (state_r == S_WB) begin
      out_r <= wb_out;
    end
  end

  pnt_ram #(.WIDTH(EW), .DEPTH(USABLE)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wd),
    .re    (mem_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  pnt_ram #(.WIDTH(32), .DEPTH(WORDS)) u_bm_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wd),
    .re    (mem_re),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

endmodule
`default_nettype wire

// ===== rtl/pnt_checker.sv =====
`default_nettype none
`include "port_right_name_table_macros.svh"
module pnt_checker import pnt_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     out_valid,
  input wire pnt_out_t out_item
);

  `PNT_ASSERT_NEXT(a_take_busy, start && !busy, busy, "item taken but busy not raised")
  `PNT_ASSERT_NEXT(a_strobe_one, out_valid, !out_valid, "result strobe longer than one cycle")
  `PNT_ASSERT_NOW(a_strobe_free, out_valid, !busy, "result shown while still busy")
  `PNT_ASSERT_NOW(a_fail_null, out_valid && (out_item.status != STAT_OK), (out_item.out_index == 10'd0) && (out_item.out_generation == 8'd0), "failed item returned a name")

endmodule

bind port_right_name_table pnt_checker u_pnt_checker (.*);
`default_nettype wire
